// File: rtl/u2bd_pkg.sv
// shared types, constants and the digit-to-character map of the base conversion core
package u2bd_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_WIDTH_DEF  = 64;

  localparam int LEN_W   = 7;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;

  localparam logic [15:0] RADIX_MIN = 16'd2;
  localparam logic [15:0] RADIX_MAX = 16'd62;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_UPPER = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0]  CHAR_LOWER = 7'h61;  // 'a'
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_UPB  = 6'd36;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] radix;
    logic [15:0] min_width;
  } u2bd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              bad_radix;
    logic [LEN_W-1:0]  length;
  } u2bd_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CALC,
    S_PAD,
    S_DIG
  } u2bd_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_UPB) begin
      c = CHAR_UPPER + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_LOWER + CHAR_W'(d - DIGIT_UPB);
    end
    return c;
  endfunction

endpackage

// File: rtl/unsigned_to_base_digits_core.sv
// top level: unsigned value to ascii digits in base 2..62, one character per word
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------------
//  request   in         start && !busy            item   (value, radix, min_width)
//  result    out        result_valid (1 cycle)    result (char_code, last, bad_radix,
//                                                         length)
//
// sequence: each digit takes a pass through the shared restoring divider
//   (DIV_BITS = min(VALUE_BITS, 32)), then a setup state (S_CALC) runs, then the
//   pad and digit states send the output characters, one per word
// a bad radix answers with one error word the next cycle and busy never rises
// reset clears the sequencer and the result strobe; the digit ram is not cleared,
//   only entries written by the current conversion are ever read
// the receiver cannot stall: every word is shown for exactly one cycle
module unsigned_to_base_digits_core import u2bd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  u2bd_in_t  item,
  output u2bd_out_t result,
  output logic      result_valid
);

  // value port is 32 bits, only the low VALUE_BITS of it count
  localparam int DIV_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);
  localparam int AW       = $clog2(VALUE_BITS);

  u2bd_state_t state, state_next;

  logic [DIGIT_W-1:0] radix, radix_next;
  logic [LEN_W-1:0]   minw, minw_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   dig_left, dig_left_next;
  logic [LEN_W-1:0]   pad_left, pad_left_next;
  logic [LEN_W-1:0]   total, total_next;
  u2bd_out_t          result_next;
  logic               result_valid_next;

  // divider hookup
  logic                div_start;
  logic [DIV_BITS-1:0] div_dividend;
  logic                div_done;
  logic [DIV_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]  div_rem;

  // digit ram hookup
  logic               ram_we;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [CNT_W-1:0]   rd_idx;

  logic accept;
  logic bad;
  logic [LEN_W-1:0] count_ext;

  assign accept    = start && !busy;
  assign bad       = (item.radix < RADIX_MIN) || (item.radix > RADIX_MAX);
  assign busy      = (state != S_IDLE);
  assign count_ext = LEN_W'(count);

  // first digit comes from the input word, later ones from the last quotient
  assign div_dividend = (state == S_IDLE) ? item.value[DIV_BITS-1:0] : div_quot;

  // read address follows the next digit pointer so the registered read data is for dig_left-1
  assign rd_idx = dig_left_next - 1'b1;

  u2bd_divider #(
    .DIV_BITS(DIV_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  u2bd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (div_rem),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      count        <= '0;
      dig_left     <= '0;
      pad_left     <= '0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      count        <= count_next;
      dig_left     <= dig_left_next;
      pad_left     <= pad_left_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    radix  <= radix_next;
    minw   <= minw_next;
    total  <= total_next;
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    radix_next        = radix;
    minw_next         = minw;
    count_next        = count;
    dig_left_next     = dig_left;
    pad_left_next     = pad_left;
    total_next        = total;
    result_valid_next = 1'b0;
    result_next       = result;
    div_start         = 1'b0;
    ram_we            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (bad) begin
            // error word, nothing else changes
            result_valid_next     = 1'b1;
            result_next.char_code = '0;
            result_next.last      = 1'b1;
            result_next.bad_radix = 1'b1;
            result_next.length    = '0;
          end else begin
            radix_next = item.radix[DIGIT_W-1:0];
            // clamp the pad target
            if (item.min_width > 16'(MAX_WIDTH)) begin
              minw_next = LEN_W'(MAX_WIDTH);
            end else begin
              minw_next = item.min_width[LEN_W-1:0];
            end
            count_next = '0;
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          // store remainder as the next digit, least significant first
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          if ((div_quot == '0) || (count + 1'b1 == CNT_W'(VALUE_BITS))) begin
            state_next = S_CALC;
          end else begin
            div_start = 1'b1;
          end
        end
      end

      S_CALC: begin
        // last ram write has landed; set up pad and the digit read pointer
        dig_left_next = count;
        if (minw > count_ext) begin
          pad_left_next = minw - count_ext;
          total_next    = minw;
          state_next    = S_PAD;
        end else begin
          pad_left_next = '0;
          total_next    = count_ext;
          state_next    = S_DIG;
        end
      end

      S_PAD: begin
        // leading zeros, never the last word since a digit always follows
        result_valid_next     = 1'b1;
        result_next.char_code = CHAR_ZERO;
        result_next.last      = 1'b0;
        result_next.bad_radix = 1'b0;
        result_next.length    = '0;
        pad_left_next         = pad_left - 1'b1;
        if (pad_left == LEN_W'(1)) begin
          state_next = S_DIG;
        end
      end

      S_DIG: begin
        // digits most significant first, ram data is for dig_left-1
        result_valid_next     = 1'b1;
        result_next.char_code = digit_char(ram_rdata);
        result_next.bad_radix = 1'b0;
        dig_left_next         = dig_left - 1'b1;
        if (dig_left == CNT_W'(1)) begin
          result_next.last   = 1'b1;
          result_next.length = total;
          state_next         = S_IDLE;
        end else begin
          result_next.last   = 1'b0;
          result_next.length = '0;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/u2bd_ram.sv
// generic single write port ram with registered read
module u2bd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/u2bd_divider.sv
// restoring divider, one quotient bit per cycle, small divisor
module u2bd_divider import u2bd_pkg::*; #(
  parameter int DIV_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DIGIT_W-1:0]  divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] quot,
  output logic [DIGIT_W-1:0]  rem
);

  localparam int CW = $clog2(DIV_BITS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DIGIT_W:0]   trial;
  logic               qbit;
  logic [DIGIT_W-1:0] rem_next;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, quot[DIV_BITS-1]};
    qbit  = (trial >= {1'b0, divisor});
    if (qbit) begin
      rem_next = DIGIT_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[DIV_BITS-2:0], qbit};
      rem  <= rem_next;
    end
  end

endmodule

// File: rtl/u2bd_checker.sv
// port level checks for the base conversion core and their bind
module u2bd_checker import u2bd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input u2bd_in_t  item,
  input u2bd_out_t result,
  input logic      result_valid
);

  logic req_bad;
  assign req_bad = (item.radix < RADIX_MIN) || (item.radix > RADIX_MAX);

  // error word has a fixed shape
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_radix |->
      result.last && (result.length == '0) && (result.char_code == '0))
    else $error("error word malformed");

  // bad radix answers with an error word and leaves busy low
  a_err_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_bad |=> result_valid && result.bad_radix && !busy)
    else $error("bad radix not answered next cycle");

  // good radix starts a conversion
  a_good_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req_bad |=> busy && !result_valid)
    else $error("conversion did not start");

  // a word that is not last belongs to a running conversion
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy && (result.length == '0))
    else $error("middle word outside a conversion");

  // a finished conversion reports a nonzero length
  a_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last && !result.bad_radix |-> (result.length != '0))
    else $error("zero length on final word");

endmodule

bind unsigned_to_base_digits_core u2bd_checker u_checker (.*);
